// File: rtl/lsme_pkg.sv
// lsme_pkg: shared constants, codes and types of the lsb stego message extractor
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package lsme_pkg;

   localparam int unsigned LENGTH_BYTES        = 4;
   localparam int unsigned MAX_EXTENSION_CHARS = 8;
   localparam int unsigned QUEUE_DEPTH         = 2;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // result kinds
   localparam logic [1:0] KIND_EXT     = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_HEADER  = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_ZERO_EXT_LEN = 3'd1;
   localparam logic [2:0] ERR_NO_DOT       = 3'd2;
   localparam logic [2:0] ERR_EXT_MISMATCH = 3'd3;
   localparam logic [2:0] ERR_ZERO_PAY_LEN = 3'd4;

   // register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_EXT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_EXT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_EXT_LEN = 2'd2;

   typedef enum logic [2:0] {
      PH_EXT_LEN,
      PH_DOT,
      PH_EXT,
      PH_PAY_LEN,
      PH_PAYLOAD,
      PH_DONE,
      PH_HALT
   } phase_type;

   // one assembled byte, flagged when a restart came since the previous one
   typedef struct packed {
      logic       restart;
      logic [7:0] data;
   } event_type;

endpackage

`default_nettype wire

// File: rtl/lsme_if.sv
// lsme_req_if / lsme_rsp_if: valid-ready channels of the extractor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface lsme_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       restart;

   modport source (output valid, pixel_byte, restart, input ready);
   modport sink   (input valid, pixel_byte, restart, output ready);
endinterface

interface lsme_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [7:0]  data_byte;
   logic [31:0] payload_length;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, item_kind, data_byte, payload_length, error_code, last,
                   input ready);
   modport sink   (input valid, item_kind, data_byte, payload_length, error_code, last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/lsme_front.sv
// lsme_front: takes carrier beats, keeps the lsb of each and assembles bytes
// depends on lsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsme_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_pixel_byte,
   input  wire logic              req_restart,
   input  wire logic              q_full,
   output logic                   q_push,
   output lsme_pkg::event_type    q_event
);
   import lsme_pkg::*;

   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [6:0] bits_ff, bits_in;
   logic       pend_ff, pend_in;

   logic       accept;
   logic [2:0] base_cnt;
   logic [6:0] base_bits;
   logic [7:0] new_bits;
   logic       pend_now;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // restart clears before this beat is used
      base_cnt  = req_restart ? 3'd0 : bit_cnt_ff;
      base_bits = req_restart ? 7'd0 : bits_ff;
      pend_now  = req_restart || pend_ff;
      new_bits  = {base_bits, req_pixel_byte[0]};

      bit_cnt_in = bit_cnt_ff;
      bits_in    = bits_ff;
      pend_in    = pend_ff;
      q_push     = 1'b0;
      q_event.restart = pend_now;
      q_event.data    = new_bits;

      if (accept) begin
         if (base_cnt == 3'd7) begin
            q_push     = 1'b1;
            bit_cnt_in = 3'd0;
            bits_in    = 7'd0;
            pend_in    = 1'b0;
         end else begin
            bit_cnt_in = base_cnt + 3'd1;
            bits_in    = new_bits[6:0];
            pend_in    = pend_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= 3'd0;
         bits_ff    <= 7'd0;
         pend_ff    <= 1'b0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         bits_ff    <= bits_in;
         pend_ff    <= pend_in;
      end
   end

   // a byte only leaves on the beat that carries its eighth bit
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> accept && (bit_cnt_ff == 3'd7 || req_restart))
      else $error("front pushed a byte without its eighth bit");

endmodule

`default_nettype wire

// File: rtl/lsme_queue.sv
// lsme_queue: short byte queue between the front and back parts
// depends on lsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsme_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lsme_pkg::event_type  push_event,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      avail,
   output lsme_pkg::event_type       head
);
   import lsme_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   event_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) ptr_next = '0;
      else ptr_next = p + PTR_W'(1);
   endfunction

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign avail = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (!push && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_event;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> avail)
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/lsme_back.sv
// lsme_back: frame parser and result register; holds the configuration registers
// depends on lsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsme_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [lsme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [63:0]                     csr_wr_data,
   input  wire logic                            q_avail,
   input  wire lsme_pkg::event_type             q_head,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_item_kind,
   output logic [7:0]                           rsp_data_byte,
   output logic [31:0]                          rsp_payload_length,
   output logic [2:0]                           rsp_error_code,
   output logic                                 rsp_last
);
   import lsme_pkg::*;

   // configuration
   logic        check_ext_ff;
   logic [63:0] exp_ext_ff;
   logic [3:0]  exp_len_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] ext_len_ff, ext_len_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] pay_rem_ff, pay_rem_in;
   logic        mis_ff, mis_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [31:0] len_ff, len_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;

   phase_type   e_phase;
   logic [31:0] e_shift, e_ext_len, e_cnt, e_pay_rem;
   logic        e_mis;
   logic [7:0]  b;
   logic [31:0] value;
   logic [31:0] cnt_inc;
   logic [31:0] rem_dec;
   logic [2:0]  char_idx;
   logic [7:0]  want;
   logic        emit;

   assign q_pop = q_avail && (!out_valid_ff || rsp_ready);

   assign rsp_valid          = out_valid_ff;
   assign rsp_item_kind      = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_last           = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ext_ff <= 1'b0;
         exp_ext_ff   <= 64'd0;
         exp_len_ff   <= 4'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHECK_EXT:   check_ext_ff <= csr_wr_data[0];
            CSR_EXP_EXT:     exp_ext_ff   <= csr_wr_data;
            CSR_EXP_EXT_LEN: exp_len_ff   <= csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // restart clears the parse state before this byte
      e_phase   = q_head.restart ? PH_EXT_LEN : phase_ff;
      e_shift   = q_head.restart ? 32'd0 : shift_ff;
      e_ext_len = q_head.restart ? 32'd0 : ext_len_ff;
      e_cnt     = q_head.restart ? 32'd0 : cnt_ff;
      e_pay_rem = q_head.restart ? 32'd0 : pay_rem_ff;
      e_mis     = q_head.restart ? 1'b0 : mis_ff;
      b         = q_head.data;
      value     = {e_shift[23:0], b};
      cnt_inc   = e_cnt + 32'd1;
      rem_dec   = e_pay_rem - 32'd1;
      char_idx  = e_cnt[2:0];
      want      = exp_ext_ff[{3'd7 - char_idx, 3'd0} +: 8];

      phase_in   = phase_ff;
      shift_in   = shift_ff;
      ext_len_in = ext_len_ff;
      cnt_in     = cnt_ff;
      pay_rem_in = pay_rem_ff;
      mis_in     = mis_ff;

      emit    = 1'b0;
      kind_in = KIND_EXT;
      data_in = 8'd0;
      len_in  = 32'd0;
      err_in  = ERR_NONE;
      last_in = 1'b0;

      if (q_pop) begin
         phase_in   = e_phase;
         shift_in   = e_shift;
         ext_len_in = e_ext_len;
         cnt_in     = e_cnt;
         pay_rem_in = e_pay_rem;
         mis_in     = e_mis;

         unique case (e_phase)
            PH_EXT_LEN, PH_PAY_LEN: begin
               if (cnt_inc < 32'(LENGTH_BYTES)) begin
                  cnt_in   = cnt_inc;
                  shift_in = value;
               end else begin
                  cnt_in   = 32'd0;
                  shift_in = 32'd0;
                  if (value == 32'd0) begin
                     phase_in = PH_HALT;
                     emit     = 1'b1;
                     kind_in  = KIND_ERROR;
                     err_in   = (e_phase == PH_EXT_LEN) ? ERR_ZERO_EXT_LEN : ERR_ZERO_PAY_LEN;
                     last_in  = 1'b1;
                  end else if (e_phase == PH_EXT_LEN) begin
                     ext_len_in = value;
                     mis_in     = check_ext_ff &&
                                  (32'(exp_len_ff) > 32'(MAX_EXTENSION_CHARS) ||
                                   value != 32'(exp_len_ff));
                     phase_in   = PH_DOT;
                  end else begin
                     pay_rem_in = value;
                     phase_in   = PH_PAYLOAD;
                     emit       = 1'b1;
                     kind_in    = KIND_HEADER;
                     len_in     = value;
                  end
               end
            end
            PH_DOT: begin
               shift_in = 32'd0;
               if (b != DOT_CHAR) begin
                  phase_in = PH_HALT;
                  emit     = 1'b1;
                  kind_in  = KIND_ERROR;
                  err_in   = ERR_NO_DOT;
                  last_in  = 1'b1;
               end else begin
                  cnt_in   = 32'd0;
                  phase_in = PH_EXT;
               end
            end
            PH_EXT: begin
               shift_in = 32'd0;
               if (check_ext_ff && e_cnt < 32'(MAX_EXTENSION_CHARS) && want != b)
                  mis_in = 1'b1;
               cnt_in  = cnt_inc;
               emit    = 1'b1;
               kind_in = KIND_EXT;
               data_in = b;
               if (cnt_inc == e_ext_len) begin
                  cnt_in   = 32'd0;
                  phase_in = PH_PAY_LEN;
                  // the last character is replaced by the mismatch error
                  if (check_ext_ff && mis_in) begin
                     phase_in = PH_HALT;
                     kind_in  = KIND_ERROR;
                     data_in  = 8'd0;
                     err_in   = ERR_EXT_MISMATCH;
                     last_in  = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               shift_in   = 32'd0;
               pay_rem_in = rem_dec;
               if (rem_dec == 32'd0) phase_in = PH_DONE;
               emit    = 1'b1;
               kind_in = KIND_PAYLOAD;
               data_in = b;
               last_in = (rem_dec == 32'd0);
            end
            PH_DONE, PH_HALT: ;
            default: phase_in = PH_HALT;
         endcase
      end

      out_valid_in = out_valid_ff;
      if (q_pop && emit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_EXT_LEN;
         shift_ff     <= 32'd0;
         ext_len_ff   <= 32'd0;
         cnt_ff       <= 32'd0;
         pay_rem_ff   <= 32'd0;
         mis_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         ext_len_ff   <= ext_len_in;
         cnt_ff       <= cnt_in;
         pay_rem_ff   <= pay_rem_in;
         mis_ff       <= mis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff  <= len_in;
         err_ff  <= err_in;
         last_ff <= last_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_ERROR |-> last_ff && err_ff != ERR_NONE)
      else $error("error beat without last or code");
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pay_rem_ff != 32'd0)
      else $error("payload phase with nothing remaining");
   assert property (@(posedge clock) disable iff (reset)
      q_pop && emit && kind_in == KIND_ERROR |=> phase_ff == PH_HALT)
      else $error("error did not halt the parser");

endmodule

`default_nettype wire

// File: rtl/lsb_stego_message_extractor.sv
// lsb_stego_message_extractor: top level, front byte assembler, queue and frame parser
// depends on lsme_pkg, lsme_if, lsme_front, lsme_queue, lsme_back
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    pixel_byte[7:0], restart
//   rsp_bus   out        valid/ready    item_kind, data_byte, payload_length, error_code, last
//   csr_*     in         csr_wr_en      csr_index[1:0], csr_wr_data[63:0]
//
// one carrier beat per cycle while the queue has room; every eighth bit forms a byte
// that the parser takes from the queue, placing any result in the result register
// the two-entry byte queue and the result register let input keep flowing while
// rsp_bus stalls; req_bus stalls only once the queue is full
// reset is synchronous and clears parse state and configuration registers; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_message_extractor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lsme_req_if.sink                             req_bus,
   lsme_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_wr_en,
   input  wire logic [lsme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [63:0]                     csr_wr_data
);
   import lsme_pkg::*;

   logic      q_full;
   logic      q_push;
   event_type q_event;
   logic      q_pop;
   logic      q_avail;
   event_type q_head;

   lsme_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_pixel_byte (req_bus.pixel_byte),
      .req_restart    (req_bus.restart),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_event        (q_event)
   );

   lsme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (q_event),
      .full       (q_full),
      .pop        (q_pop),
      .avail      (q_avail),
      .head       (q_head)
   );

   lsme_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .q_avail            (q_avail),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_item_kind      (rsp_bus.item_kind),
      .rsp_data_byte      (rsp_bus.data_byte),
      .rsp_payload_length (rsp_bus.payload_length),
      .rsp_error_code     (rsp_bus.error_code),
      .rsp_last           (rsp_bus.last)
   );

endmodule

`default_nettype wire

// File: tb/sv/lsb_stego_message_extractor_tb.sv
// lsb_stego_message_extractor_tb: self-checking bench for the lsb stego message extractor
// feeds carrier beats as frames, predicts decoded beats with a scoreboard class
// depends on lsme_pkg, lsme_if and the lsb_stego_message_extractor rtl
`timescale 1ns / 1ps

module lsb_stego_message_extractor_tb;
   import lsme_pkg::*;

   localparam logic [63:0] TXT_EXT    = {"txt", 40'h0};
   localparam int          RANDOM_BEATS = 360;
   localparam int          PHASE_BEATS  = 40;
   localparam int          SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [31:0] length;
      logic [2:0]  err;
      logic        last;
   } decoded_beat_type;

   typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_type;

   class frame_decode_tracker;
      logic             check_en;
      logic [63:0]      exp_str;
      logic [3:0]       exp_len;
      phase_type        phase;
      int unsigned      bit_cnt;
      logic [31:0]      shreg;
      logic [31:0]      ext_len;
      logic [31:0]      field_bytes;
      logic [31:0]      pay_left;
      logic             ext_bad;
      decoded_beat_type decoded_q[$];
      int               failures;

      function new();
         check_en = 1'b0;
         exp_str  = '0;
         exp_len  = '0;
         failures = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase       = PH_EXT_LEN;
         bit_cnt     = 0;
         shreg       = '0;
         ext_len     = '0;
         field_bytes = '0;
         pay_left    = '0;
         ext_bad     = 1'b0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
         case (idx)
            CSR_CHECK_EXT:   check_en = v[0];
            CSR_EXP_EXT:     exp_str  = v;
            CSR_EXP_EXT_LEN: exp_len  = v[3:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction

      function void push_beat(logic [1:0] kind, logic [7:0] data, logic [31:0] length,
                              logic [2:0] err, logic last);
         decoded_beat_type d;
         d.kind   = kind;
         d.data   = data;
         d.length = length;
         d.err    = err;
         d.last   = last;
         decoded_q.push_back(d);
      endfunction

      function void halt_with(logic [2:0] err);
         phase = PH_HALT;
         push_beat(KIND_ERROR, '0, '0, err, 1'b1);
      endfunction

      // one accepted carrier beat
      function void take_pixel(logic [7:0] px, logic rs);
         logic [7:0]  b;
         logic [31:0] val;
         logic [7:0]  want;
         if (rs) clear_parse();
         if (phase == PH_DONE || phase == PH_HALT) return;
         shreg = {shreg[30:0], px[0]};
         bit_cnt++;
         if (bit_cnt < 8) return;
         bit_cnt = 0;
         b = shreg[7:0];
         case (phase)
            PH_EXT_LEN, PH_PAY_LEN: begin
               field_bytes++;
               if (field_bytes < LENGTH_BYTES) return;
               val         = shreg;
               shreg       = '0;
               field_bytes = '0;
               if (phase == PH_EXT_LEN) begin
                  if (val == 0) begin
                     halt_with(ERR_ZERO_EXT_LEN);
                     return;
                  end
                  ext_len = val;
                  ext_bad = check_en && (exp_len > MAX_EXTENSION_CHARS || val != exp_len);
                  phase   = PH_DOT;
               end else if (val == 0) begin
                  halt_with(ERR_ZERO_PAY_LEN);
               end else begin
                  pay_left = val;
                  phase    = PH_PAYLOAD;
                  push_beat(KIND_HEADER, '0, val, ERR_NONE, 1'b0);
               end
            end
            PH_DOT: begin
               shreg = '0;
               if (b != DOT_CHAR) begin
                  halt_with(ERR_NO_DOT);
               end else begin
                  field_bytes = '0;
                  phase       = PH_EXT;
               end
            end
            PH_EXT: begin
               shreg = '0;
               if (check_en && field_bytes < MAX_EXTENSION_CHARS) begin
                  want = 8'(exp_str >> (56 - 8 * field_bytes));
                  if (want != b) ext_bad = 1'b1;
               end
               field_bytes++;
               if (field_bytes == ext_len) begin
                  field_bytes = '0;
                  phase       = PH_PAY_LEN;
                  if (check_en && ext_bad) begin
                     halt_with(ERR_EXT_MISMATCH);
                     return;
                  end
               end
               push_beat(KIND_EXT, b, '0, ERR_NONE, 1'b0);
            end
            PH_PAYLOAD: begin
               shreg = '0;
               pay_left--;
               if (pay_left == 0) phase = PH_DONE;
               push_beat(KIND_PAYLOAD, b, '0, ERR_NONE, pay_left == 0);
            end
            default: phase = PH_HALT;
         endcase
      endfunction

      function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t %s: expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_decoded(logic [1:0] kind, logic [7:0] data, logic [31:0] length,
                                  logic [2:0] err, logic last);
         decoded_beat_type d;
         if (decoded_q.size() == 0) begin
            failures++;
            $display("%0t unexpected beat: expected none actual kind %0d data %0h len %0h err %0d",
                     $time, kind, data, length, err);
            return;
         end
         d = decoded_q.pop_front();
         cmp_field("item_kind", 32'(d.kind), 32'(kind));
         cmp_field("data_byte", 32'(d.data), 32'(data));
         cmp_field("payload_length", d.length, length);
         cmp_field("error_code", 32'(d.err), 32'(err));
         cmp_field("last", 32'(d.last), 32'(last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wr_data;

   lsme_req_if req_bus();
   lsme_rsp_if rsp_bus();

   frame_decode_tracker sb = new();

   logic [7:0] frame_bytes[$];
   int         burst_left;
   int         beats_sent;
   bit         hold_req;

   lsb_stego_message_extractor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("lsb_stego_message_extractor: mismatch");
      $finish;
   end

   // receiver: its own stall pattern, plus one long hold-off on request
   initial begin
      rx_mode_type mode;
      int          span;
      int          hold;
      rsp_bus.ready = 1'b0;
      mode = RX_OPEN;
      span = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_req && hold == 0) begin
            hold     = 150;
            hold_req = 1'b0;
         end
         if (span == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
         end
         span--;
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:     rsp_bus.ready <= 1'b1;
               RX_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_bus.ready <= ((span % 5) < 2);
               default:     rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_decoded(rsp_bus.item_kind, rsp_bus.data_byte, rsp_bus.payload_length,
                          rsp_bus.error_code, rsp_bus.last);
   end

   task automatic send_beat(input logic [7:0] px, input logic rs);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.pixel_byte <= px;
      req_bus.restart    <= rs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.take_pixel(px, rs);
      beats_sent++;
   endtask

   // drop valid, wait for every decoded beat, then let in-flight bytes drain
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   task automatic set_config(input logic chk, input logic [63:0] str, input logic [3:0] len);
      write_csr(CSR_CHECK_EXT, {63'h0, chk});
      write_csr(CSR_EXP_EXT, str);
      write_csr(CSR_EXP_EXT_LEN, {60'h0, len});
   endtask

   task automatic build_frame(input logic [31:0] ext_len, input logic [7:0] dot,
                              input logic [63:0] chars, input int n_chars,
                              input logic [31:0] pay_len, input int n_pay);
      int i;
      frame_bytes.delete();
      for (i = 0; i < 4; i++) frame_bytes.push_back(ext_len[31 - 8 * i -: 8]);
      frame_bytes.push_back(dot);
      for (i = 0; i < n_chars; i++)
         frame_bytes.push_back((i < 8) ? chars[63 - 8 * i -: 8] : 8'($urandom));
      for (i = 0; i < 4; i++) frame_bytes.push_back(pay_len[31 - 8 * i -: 8]);
      for (i = 0; i < n_pay; i++) frame_bytes.push_back(8'($urandom));
   endtask

   // frame bits msb first in bit 0 of each beat; restart on the first beat
   task automatic send_frame(input int n_bits, input int noise);
      int         k;
      logic [6:0] upper;
      for (k = 0; k < n_bits && k < frame_bytes.size() * 8; k++) begin
         upper = 7'($urandom);
         send_beat({upper, frame_bytes[k / 8][7 - k % 8]}, k == 0);
      end
      repeat (noise) send_beat(8'($urandom), $urandom_range(0, 15) == 0);
   endtask

   task automatic random_frame();
      logic [31:0] el;
      logic [31:0] pl;
      logic [63:0] chars;
      logic [7:0]  dot;
      int          n_chars;
      int          n_pay;
      int          r;
      int          total;
      r = $urandom_range(0, 99);
      if (r < 5)
         el = '0;
      else if (r < 9)
         el = $urandom | 32'h100;
      else if (sb.check_en && sb.exp_len != 0 && sb.exp_len <= MAX_EXTENSION_CHARS &&
               $urandom_range(0, 3) != 0)
         el = sb.exp_len;
      else
         el = $urandom_range(1, 10);
      n_chars = (el > 12) ? $urandom_range(1, 6) : el;
      chars = ($urandom_range(0, 3) != 0) ? sb.exp_str : {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) chars = chars ^ (64'h1 << $urandom_range(0, 63));
      dot = ($urandom_range(0, 19) == 0) ? 8'($urandom) : DOT_CHAR;
      r = $urandom_range(0, 99);
      if (r < 5)
         pl = '0;
      else if (r < 9)
         pl = $urandom | 32'h80;
      else
         pl = $urandom_range(1, 6);
      n_pay = (pl > 6) ? $urandom_range(1, 4) : pl;
      build_frame(el, dot, chars, n_chars, pl, n_pay);
      total = frame_bytes.size() * 8;
      send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
   endtask

   initial begin
      int p;
      int phase_start;
      int random_start;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.pixel_byte = '0;
      req_bus.restart    = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_CHECK_EXT;
      csr_wr_data        = '0;
      burst_left         = 0;
      beats_sent         = 0;
      hold_req           = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames with checking on against "txt"
      set_config(1'b1, TXT_EXT, 4'd3);
      build_frame(32'd3, DOT_CHAR, TXT_EXT, 3, 32'd3, 3);
      send_frame(frame_bytes.size() * 8, 24);   // trailing beats are ignored unless one carries a restart
      build_frame(32'd0, DOT_CHAR, TXT_EXT, 0, 32'd1, 0);
      send_frame(40, 0);
      build_frame(32'd3, 8'h2F, TXT_EXT, 3, 32'd1, 1);
      send_frame(frame_bytes.size() * 8, 0);
      build_frame(32'd3, DOT_CHAR, {"txu", 40'h0}, 3, 32'd2, 2);
      send_frame(frame_bytes.size() * 8, 0);
      // decoded length shorter than expected
      build_frame(32'd2, DOT_CHAR, TXT_EXT, 2, 32'd1, 1);
      send_frame(frame_bytes.size() * 8, 0);
      build_frame(32'd3, DOT_CHAR, TXT_EXT, 3, 32'd0, 0);
      send_frame(frame_bytes.size() * 8, 0);
      // long extension still emits the extra chars before the error
      build_frame(32'd10, DOT_CHAR, TXT_EXT, 10, 32'd1, 1);
      send_frame(frame_bytes.size() * 8, 0);
      // max payload length, cut mid-byte; the next frame restarts
      build_frame(32'd3, DOT_CHAR, TXT_EXT, 3, 32'hFFFF_FFFF, 2);
      send_frame(frame_bytes.size() * 8 - 3, 0);
      settle();

      // expected length beyond the char limit never passes
      set_config(1'b1, '1, 4'd15);
      build_frame(32'd8, DOT_CHAR, '1, 8, 32'd1, 1);
      send_frame(frame_bytes.size() * 8, 0);
      settle();

      // checking off: any extension goes through
      set_config(1'b0, '0, 4'd0);
      build_frame(32'd5, DOT_CHAR, {$urandom, $urandom}, 5, 32'd2, 2);
      send_frame(frame_bytes.size() * 8, 8);
      build_frame(32'hFFFF_FFFF, DOT_CHAR, {$urandom, $urandom}, 4, 32'd5, 5);
      send_frame(100, 0);

      random_start = beats_sent;
      p = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         settle();
         case (p % 7)
            0: set_config(1'b0, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
            1: set_config(1'b1, {$urandom, $urandom}, 4'($urandom_range(1, 8)));
            2: set_config(1'b1, '1, 4'd8);
            3: set_config(1'b1, '0, 4'd0);
            4: set_config(1'b1, {$urandom, $urandom}, 4'd15);
            5: set_config(1'b1, {$urandom, $urandom}, 4'd1);
            default: set_config(1'b0, '0, 4'd0);
         endcase
         if (p == 1) begin
            // receiver holds off while the sender keeps streaming, so the input backs up
            hold_req   = 1'b1;
            burst_left = 300;
         end
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) random_frame();
         p++;
      end
      settle();

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("lsb_stego_message_extractor: match");
      end else begin
         $display("lsb_stego_message_extractor: mismatch");
      end
      $finish;
   end

endmodule

// File: lsb_stego_message_extractor.f
rtl/lsme_pkg.sv
rtl/lsme_if.sv
rtl/lsme_front.sv
rtl/lsme_queue.sv
rtl/lsme_back.sv
rtl/lsb_stego_message_extractor.sv
tb/sv/lsb_stego_message_extractor_tb.sv
